@@ design/smcsr_pkg.sv @@
// shared types, widths and codes for the sparse matrix csr store
package smcsr_pkg;

    // default sizing
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 1024;
    localparam int CAPACITY_DEF = 256;

    // fixed field widths
    localparam int ROW_W    = 6;
    localparam int COL_W    = 10;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int ROWCNT_W = 7;
    localparam int COLCNT_W = 11;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register reset values
    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST    = 7'd64;
    localparam logic [COLCNT_W-1:0] COLUMN_COUNT_RST = 11'd1024;

    // register index codes, taken from paddr bit 2
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // one stored entry
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] val;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic              ld_item;
        logic              rs_rd_lo;
        logic              rs_rd_hi;
        logic              lat_lo;
        logic              lat_hi;
        logic              ent_rd_scan;
        logic              ent_wr_upd;
        logic              shift_init;
        logic              ent_rd_mv;
        logic              ent_wr_mv;
        logic              ent_wr_new;
        logic              rsup_init;
        logic              rs_rd_sweep;
        logic              rs_wr;
        logic              res_set;
        logic [STAT_W-1:0] res_code;
        logic              res_from_ent;
        logic              out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_range;
        logic is_write;
        logic match;
        logic ek_lt_hi;
        logic full;
        logic ek_gt_pos;
        logic rk_le_max;
        logic out_free;
    } t_stat;

endpackage

@@ design/sparse_matrix_csr_store.sv @@
// top level of the sparse matrix csr store: config registers, controller, datapath
//
// Each input beat (i_valid / o_stall) reads or writes one matrix element by
// row and column. Each accepted beat yields exactly one output beat
// (o_valid / i_stall) with the read value or the old value and a status.
// Items are worked one at a time: o_stall is high from the cycle after
// acceptance until the result has been placed in the output register.
// An index out of range is answered straight after the range check. A read
// or overwrite scans its row's slots in order until one matches. When none
// match, a read returns zero and a write, unless the store is full, inserts
// the entry: the entries above its slot move up one slot, top down, and every
// later row start is bumped. Each memory does one read and one write a cycle;
// the next input beat can be taken in the cycle after the result is loaded.
// A held output beat does not block the input: the next item is taken and
// worked, and it waits only at the end for the output register to free.
// Reset clears the row starts (via valid bits, no clearing pass), the entry
// count and the handshake state, and loads row_count 64 and column_count
// 1024. Registers sit on the APB port at 0 and 4; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module sparse_matrix_csr_store #(
    parameter int MAX_ROWS = smcsr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smcsr_pkg::MAX_COLS_DEF,
    parameter int CAPACITY = smcsr_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smcsr_pkg::APB_AW-1:0]        paddr,
    input  logic [smcsr_pkg::APB_DW-1:0]        pwdata,
    output logic [smcsr_pkg::APB_DW-1:0]        prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [smcsr_pkg::ROW_W-1:0]         i_row,
    input  logic [smcsr_pkg::COL_W-1:0]         i_column,
    input  logic signed [smcsr_pkg::VAL_W-1:0]  i_new_value,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [smcsr_pkg::VAL_W-1:0]  o_data_value,
    output logic [smcsr_pkg::STAT_W-1:0]        o_status
);

    logic [smcsr_pkg::ROWCNT_W-1:0] r_row_count;
    logic [smcsr_pkg::COLCNT_W-1:0] r_column_count;
    logic                           cfg_wr;
    smcsr_pkg::t_cmd                cmd;
    smcsr_pkg::t_stat               stat;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= smcsr_pkg::ROW_COUNT_RST;
            r_column_count <= smcsr_pkg::COLUMN_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                smcsr_pkg::REG_ROW_COUNT: begin
                    r_row_count <= pwdata[smcsr_pkg::ROWCNT_W-1:0];
                end
                smcsr_pkg::REG_COLUMN_COUNT: begin
                    r_column_count <= pwdata[smcsr_pkg::COLCNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            smcsr_pkg::REG_ROW_COUNT:    prdata = smcsr_pkg::APB_DW'(r_row_count);
            smcsr_pkg::REG_COLUMN_COUNT: prdata = smcsr_pkg::APB_DW'(r_column_count);
            default:                     prdata = '0;
        endcase
    end

    smcsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    smcsr_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_row_count    (r_row_count),
        .i_column_count (r_column_count),
        .i_opcode       (i_opcode),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_new_value    (i_new_value),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_data_value   (o_data_value),
        .o_status       (o_status)
    );

endmodule

@@ design/smcsr_ctrl.sv @@
// controller state machine for the sparse matrix csr store
module smcsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  smcsr_pkg::t_stat i_stat,
    output smcsr_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RS1   = 4'd2;
    localparam logic [3:0] S_RS2   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_MISS  = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_RSUP  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_pend;
    logic       n_pend;

    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.in_range) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = smcsr_pkg::ST_RANGE;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rs_rd_lo = 1'b1;
                    n_state        = S_RS1;
                end
            end
            S_RS1: begin
                o_cmd.lat_lo   = 1'b1;
                o_cmd.rs_rd_hi = 1'b1;
                n_state        = S_RS2;
            end
            S_RS2: begin
                o_cmd.lat_hi = 1'b1;
                n_pend       = 1'b0;
                n_state      = S_SCAN;
            end
            // one slot read per cycle, each compared in the cycle after its read
            S_SCAN: begin
                if (r_pend && i_stat.match) begin
                    o_cmd.res_set      = 1'b1;
                    o_cmd.res_code     = smcsr_pkg::ST_OK;
                    o_cmd.res_from_ent = 1'b1;
                    o_cmd.ent_wr_upd   = i_stat.is_write;
                    n_pend             = 1'b0;
                    n_state            = S_DONE;
                end else if (i_stat.ek_lt_hi) begin
                    o_cmd.ent_rd_scan = 1'b1;
                    n_pend            = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (!i_stat.is_write) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = smcsr_pkg::ST_OK;
                    n_state        = S_DONE;
                end else if (i_stat.full) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = smcsr_pkg::ST_FULL;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_pend           = 1'b0;
                    n_state          = S_SHIFT;
                end
            end
            // move entries up one slot, top down, then drop in the new one
            S_SHIFT: begin
                o_cmd.ent_wr_mv = r_pend;
                if (i_stat.ek_gt_pos) begin
                    o_cmd.ent_rd_mv = 1'b1;
                    n_pend          = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    o_cmd.ent_wr_new = 1'b1;
                    o_cmd.rsup_init  = 1'b1;
                    n_state          = S_RSUP;
                end
            end
            // bump every later row start
            S_RSUP: begin
                o_cmd.rs_wr = r_pend;
                if (i_stat.rk_le_max) begin
                    o_cmd.rs_rd_sweep = 1'b1;
                    n_pend            = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = smcsr_pkg::ST_OK;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

@@ design/smcsr_dp.sv @@
// datapath of the sparse matrix csr store: row start and entry memories, counters, result
module smcsr_dp #(
    parameter int MAX_ROWS = smcsr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smcsr_pkg::MAX_COLS_DEF,
    parameter int CAPACITY = smcsr_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smcsr_pkg::t_cmd                     i_cmd,
    output smcsr_pkg::t_stat                    o_stat,
    input  logic [smcsr_pkg::ROWCNT_W-1:0]      i_row_count,
    input  logic [smcsr_pkg::COLCNT_W-1:0]      i_column_count,
    input  logic                                i_opcode,
    input  logic [smcsr_pkg::ROW_W-1:0]         i_row,
    input  logic [smcsr_pkg::COL_W-1:0]         i_column,
    input  logic signed [smcsr_pkg::VAL_W-1:0]  i_new_value,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [smcsr_pkg::VAL_W-1:0]  o_data_value,
    output logic [smcsr_pkg::STAT_W-1:0]        o_status
);

    localparam int RS_W = $clog2(CAPACITY + 1);
    localparam int EI_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RA_W = (MAX_ROWS > 0) ? $clog2(MAX_ROWS + 1) : 1;
    localparam int RK_W = $clog2(MAX_ROWS + 2);

    // item registers
    logic                          r_opcode;
    logic [smcsr_pkg::ROW_W-1:0]   r_row;
    logic [smcsr_pkg::COL_W-1:0]   r_col;
    logic [smcsr_pkg::VAL_W-1:0]   r_val;

    // working registers
    logic [RS_W-1:0]               r_lo;
    logic [RS_W-1:0]               r_hi;
    logic [RS_W-1:0]               r_ek;
    logic [RS_W-1:0]               r_pos;
    logic [RS_W-1:0]               r_count;
    logic [EI_W-1:0]               r_pdst;
    logic [RK_W-1:0]               r_rk;
    logic [RA_W-1:0]               r_rpdst;
    logic [smcsr_pkg::VAL_W-1:0]   r_res_value;
    logic [smcsr_pkg::STAT_W-1:0]  r_res_status;
    logic [smcsr_pkg::VAL_W-1:0]   r_out_value;
    logic [smcsr_pkg::STAT_W-1:0]  r_out_status;
    logic                          r_out_valid;

    // memories and their read data
    smcsr_pkg::t_entry             mem_ent [CAPACITY];
    smcsr_pkg::t_entry             r_ent_rdata;
    logic [RS_W-1:0]               mem_rs [MAX_ROWS + 1];
    logic [MAX_ROWS:0]             r_rs_vld;
    logic [RS_W-1:0]               r_rs_rdata;
    logic                          r_rs_rvld;

    logic [31:0]                   rows_eff;
    logic [31:0]                   cols_eff;
    logic [RS_W-1:0]               ek_m1;
    logic [RS_W-1:0]               rs_rdata_eff;
    logic [RA_W-1:0]               rs_raddr;
    logic                          rs_re;
    logic [EI_W-1:0]               ent_raddr;
    logic                          ent_re;
    logic [EI_W-1:0]               ent_waddr;
    logic                          ent_we;
    smcsr_pkg::t_entry             ent_wdata;
    smcsr_pkg::t_entry             ent_new;

    // clamped sizes
    assign rows_eff = (32'(i_row_count) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(i_row_count);
    assign cols_eff = (32'(i_column_count) > 32'(MAX_COLS)) ?
                      32'(MAX_COLS) : 32'(i_column_count);

    assign ek_m1        = r_ek - RS_W'(1);
    assign rs_rdata_eff = r_rs_rvld ? r_rs_rdata : '0;
    assign ent_new.col  = r_col;
    assign ent_new.val  = r_val;

    // status to controller
    assign o_stat.in_range  = (32'(r_row) < rows_eff) && (32'(r_col) < cols_eff);
    assign o_stat.is_write  = (r_opcode == smcsr_pkg::OP_WRITE);
    assign o_stat.match     = (r_ent_rdata.col == r_col);
    assign o_stat.ek_lt_hi  = (r_ek < r_hi) && (32'(r_ek) < 32'(CAPACITY));
    assign o_stat.full      = (32'(r_count) >= 32'(CAPACITY));
    assign o_stat.ek_gt_pos = (r_ek > r_pos);
    assign o_stat.rk_le_max = (32'(r_rk) <= 32'(MAX_ROWS));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // row start port address select
    always_comb begin
        rs_re = i_cmd.rs_rd_lo | i_cmd.rs_rd_hi | i_cmd.rs_rd_sweep;
        if (i_cmd.rs_rd_lo) begin
            rs_raddr = RA_W'(r_row);
        end else if (i_cmd.rs_rd_hi) begin
            rs_raddr = RA_W'(32'(r_row) + 32'd1);
        end else begin
            rs_raddr = r_rk[RA_W-1:0];
        end
    end

    // entry port address and data select
    always_comb begin
        ent_re    = i_cmd.ent_rd_scan | i_cmd.ent_rd_mv;
        ent_raddr = i_cmd.ent_rd_mv ? ek_m1[EI_W-1:0] : r_ek[EI_W-1:0];
        ent_we    = i_cmd.ent_wr_upd | i_cmd.ent_wr_mv | i_cmd.ent_wr_new;
        if (i_cmd.ent_wr_new) begin
            ent_waddr = r_pos[EI_W-1:0];
            ent_wdata = ent_new;
        end else if (i_cmd.ent_wr_mv) begin
            ent_waddr = r_pdst;
            ent_wdata = r_ent_rdata;
        end else begin
            ent_waddr = r_pdst;
            ent_wdata = ent_new;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_ent[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_rdata <= mem_ent[ent_raddr];
        end
    end

    // row start memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rs_wr) begin
            mem_rs[r_rpdst] <= rs_rdata_eff + RS_W'(1);
        end
        if (rs_re) begin
            r_rs_rdata <= mem_rs[rs_raddr];
            r_rs_rvld  <= r_rs_vld[rs_raddr];
        end
    end

    // row start valid bits, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_vld <= '0;
        end else if (i_cmd.rs_wr) begin
            r_rs_vld[r_rpdst] <= 1'b1;
        end
    end

    // item capture and working counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_opcode <= i_opcode;
            r_row    <= i_row;
            r_col    <= i_column;
            r_val    <= i_new_value;
        end
        if (i_cmd.lat_lo) begin
            r_lo <= rs_rdata_eff;
        end
        if (i_cmd.lat_hi) begin
            r_hi <= rs_rdata_eff;
            r_ek <= r_lo;
        end else if (i_cmd.ent_rd_scan) begin
            r_ek   <= r_ek + RS_W'(1);
            r_pdst <= r_ek[EI_W-1:0];
        end else if (i_cmd.shift_init) begin
            r_ek  <= r_count;
            r_pos <= (r_lo > r_count) ? r_count : r_lo;
        end else if (i_cmd.ent_rd_mv) begin
            r_ek   <= ek_m1;
            r_pdst <= r_ek[EI_W-1:0];
        end
        if (i_cmd.rsup_init) begin
            r_rk <= RK_W'(32'(r_row) + 32'd1);
        end else if (i_cmd.rs_rd_sweep) begin
            r_rk    <= r_rk + RK_W'(1);
            r_rpdst <= r_rk[RA_W-1:0];
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_value  <= i_cmd.res_from_ent ? r_ent_rdata.val : '0;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ent_wr_new) begin
            r_count <= r_count + RS_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

@@ design/smcsr_chk.sv @@
// port-level checker for the sparse matrix csr store, bound to the top level
module smcsr_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [smcsr_pkg::VAL_W-1:0]  o_data_value,
    input logic [smcsr_pkg::STAT_W-1:0]        o_status
);

    // one item at a time: input closes right after a beat is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while an item is in work");

    // error results carry zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != smcsr_pkg::ST_OK) |-> (o_data_value == '0))
        else $error("error result with nonzero data");

    // held output beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_value) && $stable(o_status)))
        else $error("stalled output beat changed");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind sparse_matrix_csr_store smcsr_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_data_value (o_data_value),
    .o_status     (o_status)
);
